/* src/lsch_pkg.sv */
`default_nettype none

package lsch_pkg;

  // Field widths
  localparam int unsigned OP_W        = 2;
  localparam int unsigned INDEX_W     = 3;
  localparam int unsigned ARRIVAL_W   = 16;
  localparam int unsigned BURST_W     = 16;
  localparam int unsigned TICKET_W    = 8;
  localparam int unsigned RAND_W      = 31;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned CLOCK_W     = 32;
  localparam int unsigned CLK_SUM_W   = CLOCK_W + 1;
  localparam int unsigned QUANTUM_W   = 8;
  localparam int unsigned PCOUNT_W    = 4;
  localparam int unsigned DONE_CNT_W  = 4;

  localparam logic [DONE_CNT_W-1:0] DONE_CNT_MAX = '1;

  // Defaults
  localparam int unsigned          MAX_PROCS_DEF = 8;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST   = 8'd3;
  localparam logic [PCOUNT_W-1:0]  PCOUNT_RST    = 4'd4;

  // Register file
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic {
    REG_QUANTUM = 1'b0,
    REG_PCOUNT  = 1'b1
  } reg_e;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MOD,
    S_PICK,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   remaining;
    logic [TICKET_W-1:0]  tickets;
  } entry_t;

  typedef struct packed {
    logic                 idle;
    logic [INDEX_W-1:0]   winner;
    logic [RUN_W-1:0]     run_time;
    logic [CLOCK_W-1:0]   clock_now;
    logic                 first_run;
    logic [CLOCK_W-1:0]   response_time;
    logic                 finished;
    logic [CLOCK_W-1:0]   turnaround;
    logic                 all_done;
  } res_t;

endpackage

`default_nettype wire

/* src/lsch_rem_unit.sv */
`default_nettype none

module lsch_rem_unit #(
  parameter int unsigned DIVIDEND_W = lsch_pkg::RAND_W,
  parameter int unsigned DIVISOR_W  = 11
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVISOR_W-1:0]       rem_o
);
  import lsch_pkg::*;

  // Restoring remainder, two quotient bits a cycle
  localparam int unsigned BITS_PER_CYCLE = 2;
  localparam int unsigned STEPS = (DIVIDEND_W + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int unsigned DIV_W = STEPS * BITS_PER_CYCLE;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;

  logic [DIVISOR_W-1:0] rem_step;
  logic [DIV_W-1:0]     div_step;

  always_comb begin
    logic [DIVISOR_W:0] trial;
    rem_step = rem_q;
    div_step = div_q;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      trial    = {rem_step, div_step[DIV_W-1]};
      div_step = {div_step[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      rem_step = trial[DIVISOR_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = DIV_W'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      div_d = div_step;
      rem_d = rem_step;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* src/lottery_scheduler.sv */
// Lottery time-slice scheduler. Issue one transaction with start_i while busy_o is low:
// a load writes one process entry, a restart clears the clock and the completion
// count, and a step draws one lottery among the processes that have arrived and
// still have work. Every transaction gives exactly one result, shown for a single
// cycle with done_o high; the receiver cannot stall, so capture it in that cycle.
// busy_o stays high from acceptance until the cycle that carries done_o, and a new
// transaction may be issued in that same cycle. A load, a restart and a step that
// finds nothing to do (all work done) skip the table and return their result
// straight from the response state. A full step with n processes in use makes
// two passes over the process table through its single read port (one entry a
// cycle) and uses the shared remainder unit, which resolves the winning ticket two
// bits a cycle over the 31-bit random word. A step with no eligible process skips
// the draw and returns after the first pass. Program quantum and process_count over
// the APB port only while the block is idle.

`default_nettype none

module lottery_scheduler #(
  parameter int unsigned MAX_PROCS = lsch_pkg::MAX_PROCS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  // APB register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lsch_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [lsch_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [lsch_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,

  // Command side
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [lsch_pkg::OP_W-1:0]        op_i,
  input  wire logic [lsch_pkg::INDEX_W-1:0]     entry_index_i,
  input  wire logic [lsch_pkg::ARRIVAL_W-1:0]   arrival_i,
  input  wire logic [lsch_pkg::BURST_W-1:0]     burst_i,
  input  wire logic [lsch_pkg::TICKET_W-1:0]    tickets_i,
  input  wire logic [lsch_pkg::RAND_W-1:0]      random_word_i,

  // Result side
  output logic                                  done_o,
  output logic                                  idle_o,
  output logic      [lsch_pkg::INDEX_W-1:0]     winner_o,
  output logic      [lsch_pkg::RUN_W-1:0]       run_time_o,
  output logic      [lsch_pkg::CLOCK_W-1:0]     clock_now_o,
  output logic                                  first_run_o,
  output logic      [lsch_pkg::CLOCK_W-1:0]     response_time_o,
  output logic                                  finished_o,
  output logic      [lsch_pkg::CLOCK_W-1:0]     turnaround_o,
  output logic                                  all_done_o
);
  import lsch_pkg::*;

  // Table address, process count and ticket total widths
  localparam int unsigned IW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned NW    = $clog2(MAX_PROCS + 1);
  localparam int unsigned TOT_W = TICKET_W + $clog2(MAX_PROCS);

  function automatic logic [CLOCK_W-1:0] sat_add(input logic [CLOCK_W-1:0] a,
                                                 input logic [CLOCK_W-1:0] b);
    logic [CLK_SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CLOCK_W] ? '1 : s[CLOCK_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [QUANTUM_W-1:0] quantum_q;
  logic [PCOUNT_W-1:0]  pcount_q;
  reg_e                 reg_sel;

  assign reg_sel = reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RST;
      pcount_q  <= PCOUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_QUANTUM: quantum_q <= pwdata[QUANTUM_W-1:0];
        REG_PCOUNT:  pcount_q  <= pwdata[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_QUANTUM: prdata = APB_DATA_W'(quantum_q);
      REG_PCOUNT:  prdata = APB_DATA_W'(pcount_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [CLOCK_W-1:0]    clock_q, clock_d;
  logic [DONE_CNT_W-1:0] done_cnt_q, done_cnt_d;
  // work_q mirrors "remaining work is non-zero" per entry, started_q the first-run marks
  logic [MAX_PROCS-1:0]  work_q, work_d;
  logic [MAX_PROCS-1:0]  started_q, started_d;

  // Table scan
  logic [NW-1:0]         idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [IW-1:0]         pidx_q, pidx_d;
  logic [TOT_W-1:0]      sum_q, sum_d;
  logic [TOT_W-1:0]      total_q, total_d;
  logic [IW-1:0]         win_idx_q, win_idx_d;
  entry_t                win_q, win_d;
  logic [RAND_W-1:0]     rand_q, rand_d;

  // Result assembly and output register
  res_t                  res_q, res_d;
  res_t                  out_q, out_d;
  logic                  done_q, done_d;

  // Process table: one write port, one registered read port
  entry_t                mem [MAX_PROCS];
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  entry_t                mem_wdata;
  logic [IW-1:0]         rd_addr;
  entry_t                rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared remainder unit: winning ticket = random word mod ticket total
  // ---------------------------------------------------------------------------
  logic             mod_start;
  logic             mod_done;
  logic [TOT_W-1:0] mod_rem;

  lsch_rem_unit #(
    .DIVIDEND_W (RAND_W),
    .DIVISOR_W  (TOT_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rand_q),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // ---------------------------------------------------------------------------
  // Derived control
  // ---------------------------------------------------------------------------
  logic [NW-1:0]        n_use;
  logic                 any_work;
  logic                 all_done_now;
  logic                 scan_more;
  logic                 elig;
  logic [TOT_W-1:0]     sum_next;
  logic [IW-1:0]        load_idx;
  logic                 load_ok;
  logic [QUANTUM_W-1:0] q_eff;
  logic [RUN_W-1:0]     run;
  logic [BURST_W-1:0]   new_rem;

  // Clamp the process count to the table size
  assign n_use = (32'(pcount_q) > MAX_PROCS) ? NW'(MAX_PROCS) : NW'(pcount_q);

  // Every entry in use has drained its work
  always_comb begin
    any_work = 1'b0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if ((i < int'(n_use)) && work_q[i]) begin
        any_work = 1'b1;
      end
    end
  end
  assign all_done_now = !any_work;

  assign scan_more = (idx_q < n_use);
  // An entry that returns from the read port takes part if it has arrived and has work
  assign elig      = pend_q && work_q[pidx_q] && (CLOCK_W'(rd_q.arrival) <= clock_q);
  assign sum_next  = sum_q + TOT_W'(rd_q.tickets);

  assign load_idx  = IW'(entry_index_i);
  assign load_ok   = (32'(entry_index_i) < MAX_PROCS);

  // A zero quantum acts as one; run for the smaller of quantum and remaining work
  assign q_eff     = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;
  assign run       = (win_q.remaining < BURST_W'(q_eff)) ? RUN_W'(win_q.remaining) : q_eff;
  assign new_rem   = win_q.remaining - BURST_W'(run);

  // ---------------------------------------------------------------------------
  // Sequencer: next state and datapath updates
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    clock_d    = clock_q;
    done_cnt_d = done_cnt_q;
    work_d     = work_q;
    started_d  = started_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    sum_d      = sum_q;
    total_d    = total_q;
    win_idx_d  = win_idx_q;
    win_d      = win_q;
    rand_d     = rand_q;
    res_d      = res_q;
    out_d      = out_q;
    done_d     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = load_idx;
    mem_wdata  = win_q;
    rd_addr    = idx_q[IW-1:0];
    mod_start  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d  = '0;
          rand_d = random_word_i;
          case (op_e'(op_i))
            OP_LOAD: begin
              // Write the entry; out-of-range indexes are dropped
              if (load_ok) begin
                mem_we            = 1'b1;
                mem_waddr         = load_idx;
                mem_wdata.arrival = arrival_i;
                mem_wdata.remaining = burst_i;
                mem_wdata.tickets = (tickets_i == '0) ? TICKET_W'(1) : tickets_i;
                work_d[load_idx]    = (burst_i != '0);
                started_d[load_idx] = 1'b0;
              end
              state_d = S_RESP;
            end
            OP_RESTART: begin
              clock_d    = '0;
              done_cnt_d = '0;
              state_d    = S_RESP;
            end
            OP_STEP: begin
              // Nothing left to run: report the clock unchanged
              if (all_done_now) begin
                state_d = S_RESP;
              end else begin
                idx_d   = '0;
                sum_d   = '0;
                state_d = S_SUM;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_SUM: begin
        // First pass: total the tickets of eligible entries
        if (scan_more) begin
          pend_d = 1'b1;
          pidx_d = idx_q[IW-1:0];
          idx_d  = idx_q + NW'(1);
        end
        if (elig) begin
          sum_d = sum_next;
        end
        if (!scan_more && !pend_q) begin
          if (sum_q == '0) begin
            // Nobody ready: advance the clock by one and flag idle
            clock_d    = sat_add(clock_q, CLOCK_W'(1));
            res_d.idle = 1'b1;
            state_d    = S_RESP;
          end else begin
            total_d   = sum_q;
            mod_start = 1'b1;
            idx_d     = '0;
            sum_d     = '0;
            state_d   = S_MOD;
          end
        end
      end

      S_MOD: begin
        if (mod_done) begin
          state_d = S_PICK;
        end
      end

      S_PICK: begin
        // Second pass: first eligible entry whose running sum exceeds the draw
        if (scan_more) begin
          pend_d = 1'b1;
          pidx_d = idx_q[IW-1:0];
          idx_d  = idx_q + NW'(1);
        end
        if (elig) begin
          sum_d = sum_next;
          if (mod_rem < sum_next) begin
            win_idx_d = pidx_q;
            win_d     = rd_q;
            pend_d    = 1'b0;
            state_d   = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        // Run the winner and write back its remaining work
        mem_we              = 1'b1;
        mem_waddr           = win_idx_q;
        mem_wdata.arrival   = win_q.arrival;
        mem_wdata.remaining = new_rem;
        mem_wdata.tickets   = win_q.tickets;
        work_d[win_idx_q]    = (new_rem != '0);
        started_d[win_idx_q] = 1'b1;
        win_d.remaining      = new_rem;
        clock_d = sat_add(clock_q, CLOCK_W'(run));

        res_d.winner   = INDEX_W'(win_idx_q);
        res_d.run_time = run;
        if (!started_q[win_idx_q]) begin
          res_d.first_run     = 1'b1;
          res_d.response_time = clock_q - CLOCK_W'(win_q.arrival);
        end
        if (new_rem == '0) begin
          res_d.finished = 1'b1;
          if (done_cnt_q != DONE_CNT_MAX) begin
            done_cnt_d = done_cnt_q + DONE_CNT_W'(1);
          end
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        // Register the result; clock and completion status are final by now
        out_d           = res_q;
        out_d.clock_now = clock_q;
        out_d.turnaround = res_q.finished ? (clock_q - CLOCK_W'(win_q.arrival)) : '0;
        out_d.all_done  = all_done_now;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q    <= '0;
      done_cnt_q <= '0;
      work_q     <= '0;
      started_q  <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      clock_q    <= clock_d;
      done_cnt_q <= done_cnt_d;
      work_q     <= work_d;
      started_q  <= started_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    sum_q     <= sum_d;
    total_q   <= total_d;
    win_idx_q <= win_idx_d;
    win_q     <= win_d;
    rand_q    <= rand_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign idle_o          = out_q.idle;
  assign winner_o        = out_q.winner;
  assign run_time_o      = out_q.run_time;
  assign clock_now_o     = out_q.clock_now;
  assign first_run_o     = out_q.first_run;
  assign response_time_o = out_q.response_time;
  assign finished_o      = out_q.finished;
  assign turnaround_o    = out_q.turnaround;
  assign all_done_o      = out_q.all_done;

endmodule

`default_nettype wire

/* tb/sv/lsch_checker.sv */
`timescale 1ns / 100ps

module lsch_checker
  import lsch_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,

  input  logic                  start_i,
  input  logic                  busy_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [INDEX_W-1:0]    entry_index_i,
  input  logic [ARRIVAL_W-1:0]  arrival_i,
  input  logic [BURST_W-1:0]    burst_i,
  input  logic [TICKET_W-1:0]   tickets_i,
  input  logic [RAND_W-1:0]     random_word_i,

  input  logic                  done_o,
  input  logic                  idle_o,
  input  logic [INDEX_W-1:0]    winner_o,
  input  logic [RUN_W-1:0]      run_time_o,
  input  logic [CLOCK_W-1:0]    clock_now_o,
  input  logic                  first_run_o,
  input  logic [CLOCK_W-1:0]    response_time_o,
  input  logic                  finished_o,
  input  logic [CLOCK_W-1:0]    turnaround_o,
  input  logic                  all_done_o,

  output int unsigned           mismatch_count,
  output int unsigned           reports_pending
);

  // Shadow of the process table and scheduler state
  logic [ARRIVAL_W-1:0]  arrival_q   [MAX_PROCS];
  logic [BURST_W-1:0]    remaining_q [MAX_PROCS];
  logic [TICKET_W-1:0]   tickets_q   [MAX_PROCS];
  logic                  started_q   [MAX_PROCS];
  logic [CLOCK_W-1:0]    sched_clock;
  logic [DONE_CNT_W-1:0] done_count;
  logic [QUANTUM_W-1:0]  quantum_r;
  logic [PCOUNT_W-1:0]   pcount_r;

  res_t report_q [$];

  function automatic int unsigned procs_in_use();
    return (pcount_r > MAX_PROCS) ? MAX_PROCS : int'(pcount_r);
  endfunction

  function automatic logic all_finished();
    logic fin;
    fin = 1'b1;
    for (int unsigned i = 0; i < procs_in_use(); i++)
      if (remaining_q[i] != '0) fin = 1'b0;
    return fin;
  endfunction

  function automatic logic [CLOCK_W-1:0] clock_plus(input logic [CLOCK_W-1:0] base,
                                                    input logic [CLOCK_W-1:0] delta);
    logic [CLK_SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, delta};
    return sum[CLOCK_W] ? '1 : sum[CLOCK_W-1:0];
  endfunction

  // Apply one transaction to the shadow state and return the report it must produce.
  function automatic res_t schedule_item(input logic [OP_W-1:0]      op,
                                         input logic [INDEX_W-1:0]   idx,
                                         input logic [ARRIVAL_W-1:0] arr,
                                         input logic [BURST_W-1:0]   work,
                                         input logic [TICKET_W-1:0]  tix,
                                         input logic [RAND_W-1:0]    rword);
    res_t                 r;
    int unsigned          n, pool, draw, acc, w;
    logic                 found;
    logic [QUANTUM_W-1:0] slice;
    logic [RUN_W-1:0]     ran;
    r = '0;
    n = procs_in_use();
    case (op)
      OP_LOAD: begin
        if (idx < MAX_PROCS) begin
          arrival_q[idx]   = arr;
          remaining_q[idx] = work;
          tickets_q[idx]   = (tix == '0) ? TICKET_W'(1) : tix;
          started_q[idx]   = 1'b0;
        end
      end
      OP_RESTART: begin
        sched_clock = '0;
        done_count  = '0;
      end
      OP_STEP: begin
        if (!all_finished()) begin
          pool = 0;
          for (int unsigned i = 0; i < n; i++)
            if (arrival_q[i] <= sched_clock && remaining_q[i] != '0) pool += tickets_q[i];
          if (pool == 0) begin
            sched_clock = clock_plus(sched_clock, CLOCK_W'(1));
            r.idle      = 1'b1;
          end else begin
            draw  = rword % pool;
            acc   = 0;
            w     = 0;
            found = 1'b0;
            for (int unsigned i = 0; i < n; i++) begin
              if (!found && arrival_q[i] <= sched_clock && remaining_q[i] != '0) begin
                acc += tickets_q[i];
                if (draw < acc) begin
                  w     = i;
                  found = 1'b1;
                end
              end
            end
            r.winner = w[INDEX_W-1:0];
            if (!started_q[w]) begin
              started_q[w]    = 1'b1;
              r.first_run     = 1'b1;
              r.response_time = sched_clock - arrival_q[w];
            end
            slice        = (quantum_r == '0) ? QUANTUM_W'(1) : quantum_r;
            ran          = (remaining_q[w] < slice) ? remaining_q[w][RUN_W-1:0] : slice;
            r.run_time   = ran;
            sched_clock  = clock_plus(sched_clock, CLOCK_W'(ran));
            remaining_q[w] = remaining_q[w] - BURST_W'(ran);
            if (remaining_q[w] == '0) begin
              r.finished   = 1'b1;
              r.turnaround = sched_clock - arrival_q[w];
              if (done_count != DONE_CNT_MAX) done_count++;
            end
          end
        end
      end
      default: ;
    endcase
    r.clock_now = sched_clock;
    r.all_done  = all_finished();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAX_PROCS; i++) begin
        arrival_q[i]   = '0;
        remaining_q[i] = '0;
        tickets_q[i]   = '0;
        started_q[i]   = 1'b0;
      end
      sched_clock = '0;
      done_count  = '0;
      quantum_r   = QUANTUM_RST;
      pcount_r    = PCOUNT_RST;
      report_q.delete();
    end else begin
      // register port: writes update the shadow, reads are checked against it
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_e'(paddr[2]))
            REG_QUANTUM: quantum_r = pwdata[QUANTUM_W-1:0];
            REG_PCOUNT:  pcount_r  = pwdata[PCOUNT_W-1:0];
            default: ;
          endcase
        end else begin
          case (reg_e'(paddr[2]))
            REG_QUANTUM: check_field("prdata quantum", 32'(quantum_r), prdata);
            REG_PCOUNT:  check_field("prdata process_count", 32'(pcount_r), prdata);
            default: ;
          endcase
        end
      end

      if (done_o) begin
        if (report_q.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          mismatch_count++;
        end else begin
          want = report_q.pop_front();
          check_field("idle",          32'(want.idle),          32'(idle_o));
          check_field("winner",        32'(want.winner),        32'(winner_o));
          check_field("run_time",      32'(want.run_time),      32'(run_time_o));
          check_field("clock_now",     want.clock_now,          clock_now_o);
          check_field("first_run",     32'(want.first_run),     32'(first_run_o));
          check_field("response_time", want.response_time,      response_time_o);
          check_field("finished",      32'(want.finished),      32'(finished_o));
          check_field("turnaround",    want.turnaround,         turnaround_o);
          check_field("all_done",      32'(want.all_done),      32'(all_done_o));
        end
      end

      // append the prediction for the transaction taken at this edge
      if (start_i && !busy_o) begin
        want     = schedule_item(op_i, entry_index_i, arrival_i, burst_i, tickets_i,
                                 random_word_i);
        report_q = {report_q, want};
      end
    end
    reports_pending = report_q.size();
  end

endmodule

/* tb/sv/lottery_scheduler_tb.sv */
`timescale 1ns / 100ps

module lottery_scheduler_tb;
  import lsch_pkg::*;

  localparam int unsigned MAX_PROCS   = MAX_PROCS_DEF;
  // the block treats this op code as a no-op status request
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned ITEM_TARGET = 1000;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned STEP_CAP    = 90;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned DRAIN_LIMIT = 5000;
  // roughly 1100 transactions plus sender gaps, taken several times over
  localparam int unsigned CYCLE_LIMIT = 600_000;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  start_i       = 1'b0;
  logic                  busy_o;
  logic [OP_W-1:0]       op_i          = '0;
  logic [INDEX_W-1:0]    entry_index_i = '0;
  logic [ARRIVAL_W-1:0]  arrival_i     = '0;
  logic [BURST_W-1:0]    burst_i       = '0;
  logic [TICKET_W-1:0]   tickets_i     = '0;
  logic [RAND_W-1:0]     random_word_i = '0;

  logic                  done_o;
  logic                  idle_o;
  logic [INDEX_W-1:0]    winner_o;
  logic [RUN_W-1:0]      run_time_o;
  logic [CLOCK_W-1:0]    clock_now_o;
  logic                  first_run_o;
  logic [CLOCK_W-1:0]    response_time_o;
  logic                  finished_o;
  logic [CLOCK_W-1:0]    turnaround_o;
  logic                  all_done_o;

  int unsigned           mismatch_count;
  int unsigned           reports_pending;
  int unsigned           items_sent = 0;
  int unsigned           burst_left = 0;
  int unsigned           cycle_count = 0;

  // Toggle the clock every half period (10 ns period)
  always #5 clk_i = ~clk_i;

  lottery_scheduler #(.MAX_PROCS(MAX_PROCS)) dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .busy_o, .op_i, .entry_index_i, .arrival_i, .burst_i, .tickets_i,
    .random_word_i,
    .done_o, .idle_o, .winner_o, .run_time_o, .clock_now_o, .first_run_o,
    .response_time_o, .finished_o, .turnaround_o, .all_done_o
  );

  // Watch both channels and the register port; predict and compare every report
  lsch_checker #(.MAX_PROCS(MAX_PROCS)) u_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .busy_o, .op_i, .entry_index_i, .arrival_i, .burst_i, .tickets_i,
    .random_word_i,
    .done_o, .idle_o, .winner_o, .run_time_o, .clock_now_o, .first_run_o,
    .response_time_o, .finished_o, .turnaround_o, .all_done_o,
    .mismatch_count, .reports_pending
  );

  // Guard against a hang: abandon the run once the cycle budget is spent
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Issue one transaction and hold it until the block takes it. The sender works
  // in bursts: when a burst runs out, drop start for a random gap (sometimes none)
  // so that pauses land on every phase of the block's work. start is left high on
  // return so that back-to-back transactions never lower and raise it in one step.
  task automatic send_item(input logic [OP_W-1:0]      op,
                           input logic [INDEX_W-1:0]   idx,
                           input logic [ARRIVAL_W-1:0] arr,
                           input logic [BURST_W-1:0]   work,
                           input logic [TICKET_W-1:0]  tix,
                           input logic [RAND_W-1:0]    rword);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i       <= 1'b1;
    op_i          <= op;
    entry_index_i <= idx;
    arrival_i     <= arr;
    burst_i       <= work;
    tickets_i     <= tix;
    random_word_i <= rword;
    // busy_o read here is its value before the edge, i.e. the one that decides acceptance
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop start and wait, on falling edges, until every report is back and the
  // block is idle; return aligned to a rising edge
  task automatic settle(input int unsigned max_cycles);
    int unsigned waited;
    waited = 0;
    start_i <= 1'b0;
    @(negedge clk_i);
    while ((reports_pending != 0 || busy_o) && waited < max_cycles) begin
      @(negedge clk_i);
      waited++;
    end
    @(posedge clk_i);
  endtask

  // One APB transfer: setup then access. psel is left high so that consecutive
  // transfers don't lower and raise it within one step; the caller drops it.
  task automatic apb_access(input logic is_write, input reg_e which, input logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {which, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // Write both registers and read them back; only called with the block idle
  task automatic program_regs(input logic [QUANTUM_W-1:0] q, input logic [PCOUNT_W-1:0] pc);
    apb_access(1'b1, REG_QUANTUM, 32'(q));
    apb_access(1'b1, REG_PCOUNT,  32'(pc));
    apb_access(1'b0, REG_QUANTUM, '0);
    apb_access(1'b0, REG_PCOUNT,  '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A well-formed workload: restart, load every entry in use with small arrivals
  // and mostly short bursts, then step roughly until the table drains or the
  // phase's share of transactions runs out. Now and then skip the restart or slip
  // a stray transaction in between the steps.
  task automatic run_workload(input int unsigned n_used, input int unsigned slice,
                              input int unsigned stop_at);
    int unsigned          budget, latest, n_steps, pick;
    logic [ARRIVAL_W-1:0] arr;
    logic [BURST_W-1:0]   work;
    budget = 0;
    latest = 0;
    if ($urandom_range(0, 9) != 0)
      send_item(OP_RESTART, INDEX_W'($urandom()), ARRIVAL_W'($urandom()),
                BURST_W'($urandom()), TICKET_W'($urandom()), RAND_W'($urandom()));
    for (int unsigned k = 0; k < n_used; k++) begin
      arr  = ARRIVAL_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 60)
                                                    : $urandom_range(0, 6));
      pick = $urandom_range(0, 9);
      if (pick == 0)      work = '0;
      else if (pick == 1) work = BURST_W'($urandom_range(13, 400));
      else                work = BURST_W'($urandom_range(1, 12));
      send_item(OP_LOAD, INDEX_W'(k), arr, work, TICKET_W'($urandom_range(0, 255)),
                RAND_W'($urandom()));
      budget += (work + slice - 1) / slice;
      if (arr > latest) latest = 32'(arr);
    end
    n_steps = budget + latest + $urandom_range(0, 3);
    if (n_steps > STEP_CAP) n_steps = STEP_CAP;
    for (int unsigned k = 0; k < n_steps && items_sent < stop_at; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_item(OP_SPARE, INDEX_W'($urandom()), ARRIVAL_W'($urandom()),
                    BURST_W'($urandom()), TICKET_W'($urandom()), RAND_W'($urandom()));
        else
          send_item(OP_LOAD, INDEX_W'($urandom()), ARRIVAL_W'($urandom_range(0, 20)),
                    BURST_W'($urandom_range(0, 20)), TICKET_W'($urandom()),
                    RAND_W'($urandom()));
      end else begin
        send_item(OP_STEP, INDEX_W'($urandom()), ARRIVAL_W'($urandom()),
                  BURST_W'($urandom()), TICKET_W'($urandom()), RAND_W'($urandom()));
      end
    end
  endtask

  initial begin
    logic [QUANTUM_W-1:0] q_set;
    logic [PCOUNT_W-1:0]  pc_set;
    int unsigned          phase_end, n_used, slice;

    // Hold reset, then release it on a rising edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset settings (quantum 3, four entries in use).
    // A step straight after reset: nothing has work, so all_done with no change.
    send_item(OP_STEP,    '0, '0, '0, '0, '0);
    send_item(OP_SPARE,   '1, '1, '1, '1, '1);
    send_item(OP_RESTART, '0, '0, '0, '0, '0);
    // Field extremes; the entry has not arrived, so the next step idles
    send_item(OP_LOAD,    3'd0, 16'hFFFF, 16'hFFFF, 8'hFF, '0);
    send_item(OP_STEP,    '0, '0, '0, '0, 31'h0);
    // Entry outside the in-use range must never take part
    send_item(OP_LOAD,    3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, '1);
    // Zero tickets are stored as one; a zero burst counts as done
    send_item(OP_LOAD,    3'd0, 16'd0, 16'd5, 8'd0, '0);
    send_item(OP_LOAD,    3'd1, 16'd0, 16'd0, 8'd1, '0);
    send_item(OP_LOAD,    3'd2, 16'd2, 16'd4, 8'd255, '0);
    send_item(OP_LOAD,    3'd3, 16'd3, 16'd2, 8'd128, '0);
    send_item(OP_STEP,    '0, '0, '0, '0, 31'h7FFF_FFFF);
    send_item(OP_STEP,    '0, '0, '0, '0, 31'h0);
    repeat (4) send_item(OP_STEP, '0, '0, '0, '0, RAND_W'($urandom()));
    // Restart clears the clock and the count but keeps the table
    send_item(OP_RESTART, '0, '0, '0, '0, '0);
    repeat (6) send_item(OP_STEP, '0, '0, '0, '0, RAND_W'($urandom()));
    send_item(OP_SPARE,   '0, '0, '0, '0, '0);

    // Random part: several register settings, extremes first. Each phase starts
    // with the block drained, so the sender pauses until every report is back.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin q_set = 8'd1;   pc_set = 4'd8;  end
        1:       begin q_set = 8'd255; pc_set = 4'd1;  end
        2:       begin q_set = 8'd0;   pc_set = 4'd15; end
        3:       begin q_set = 8'd3;   pc_set = 4'd0;  end
        4:       begin q_set = 8'd8;   pc_set = 4'd8;  end
        default: begin
          q_set  = QUANTUM_W'($urandom_range(1, 6));
          pc_set = PCOUNT_W'($urandom_range(0, 15));
        end
      endcase
      settle(DRAIN_LIMIT);
      program_regs(q_set, pc_set);
      n_used    = (pc_set > MAX_PROCS) ? MAX_PROCS : pc_set;
      slice     = (q_set == 0) ? 1 : q_set;
      phase_end = items_sent + ITEM_TARGET / NUM_PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: fully random fields, any op code
          repeat ($urandom_range(4, 10))
            send_item(OP_W'($urandom_range(0, 3)), INDEX_W'($urandom()),
                      ARRIVAL_W'($urandom()), BURST_W'($urandom()), TICKET_W'($urandom()),
                      RAND_W'($urandom()));
        end else begin
          run_workload(n_used, slice, phase_end);
        end
      end
    end

    // Drain, let the block go quiet, then give the verdict
    settle(DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* lottery_scheduler.f */
src/lsch_pkg.sv
src/lsch_rem_unit.sv
src/lottery_scheduler.sv
tb/sv/lsch_checker.sv
tb/sv/lottery_scheduler_tb.sv
